// File: rtl/ialu_pkg.sv
package ialu_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_GCD = 3'd5,
        OP_LCM = 3'd6,
        OP_BAD = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DIV0   = 2'd1,
        ST_NOTPOS = 2'd2,
        ST_BADOP  = 2'd3
    } t_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_DIV,
        S_GCD,
        S_LDIV_INIT,
        S_LDIV,
        S_LMUL,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_req;

    typedef struct packed {
        logic signed [63:0] value;
        logic [1:0]         status;
    } t_res;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic div_lcm_init;
        logic gcd_step;
        logic mul_en;
        logic mul_lcm;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic zero_b;
        logic notpos;
        logic div_last;
        logic gcd_eq;
    } t_sts;

endpackage

// File: rtl/ialu_ctrl.sv
module ialu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ialu_pkg::t_sts i_sts,
    output ialu_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import ialu_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_sts.op)
                    OP_MUL: n_state = S_MUL;
                    OP_DIV, OP_MOD: n_state = i_sts.zero_b ? S_FIN : S_DIV;
                    OP_GCD, OP_LCM: n_state = i_sts.notpos ? S_FIN : S_GCD;
                    default: n_state = S_FIN;
                endcase
            end
            S_MUL: n_state = S_FIN;
            S_DIV: begin
                if (i_sts.div_last) n_state = S_FIN;
            end
            S_GCD: begin
                if (i_sts.gcd_eq) n_state = (i_sts.op == OP_LCM) ? S_LDIV_INIT : S_FIN;
            end
            S_LDIV_INIT: n_state = S_LDIV;
            S_LDIV: begin
                if (i_sts.div_last) n_state = S_LMUL;
            end
            S_LMUL: n_state = S_FIN;
            S_FIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:      o_cmd.load = i_start;
            S_MUL:       o_cmd.mul_en = 1'b1;
            S_DIV:       o_cmd.div_step = 1'b1;
            S_GCD:       o_cmd.gcd_step = !i_sts.gcd_eq;
            S_LDIV_INIT: o_cmd.div_lcm_init = 1'b1;
            S_LDIV:      o_cmd.div_step = 1'b1;
            S_LMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_lcm = 1'b1;
            end
            S_FIN:       o_cmd.finish = 1'b1;
            default:     o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: rtl/ialu_dp.sv
module ialu_dp #(
    parameter int W = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ialu_pkg::t_req i_req,
    input  ialu_pkg::t_cmd i_cmd,
    output ialu_pkg::t_sts o_sts,
    output logic           o_valid,
    output ialu_pkg::t_res o_res
);
    import ialu_pkg::*;

    localparam int CW = $clog2(W);

    t_op                 r_op;
    logic signed [W-1:0] r_a, r_b;
    logic [W-1:0]        r_u, r_v;
    logic [CW-1:0]       r_k;
    logic [W-1:0]        r_dvd, r_dvs, r_rem;
    logic [CW-1:0]       r_cnt;
    logic signed [2*W-1:0] r_prod;
    logic                r_valid;
    t_res                r_res;

    logic signed [W-1:0] in_a, in_b;
    logic [W-1:0]        mag_a, mag_b, gcd_g;
    logic [W:0]          rem_sh;
    logic                q_bit;
    logic signed [W-1:0] mul_x;
    logic signed [W-1:0] sum_w, dif_w;
    logic signed [63:0]  res_val;
    t_stat               res_st;

    assign in_a  = i_req.operand_a[W-1:0];
    assign in_b  = i_req.operand_b[W-1:0];
    assign mag_a = in_a[W-1] ? W'(-in_a) : in_a;
    assign mag_b = in_b[W-1] ? W'(-in_b) : in_b;

    // restoring divide, one quotient bit per step
    assign rem_sh = {r_rem, r_dvd[W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_dvs});

    assign gcd_g = r_u << r_k;
    assign mul_x = i_cmd.mul_lcm ? $signed(r_dvd) : r_a;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_req.req_type);
            r_a   <= in_a;
            r_b   <= in_b;
            r_u   <= in_a;
            r_v   <= in_b;
            r_k   <= '0;
            r_dvd <= mag_a;
            r_dvs <= mag_b;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_lcm_init) begin
            r_dvd <= r_a;
            r_dvs <= gcd_g;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? W'(rem_sh - {1'b0, r_dvs}) : rem_sh[W-1:0];
            r_dvd <= {r_dvd[W-2:0], q_bit};
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.gcd_step) begin
            // binary gcd
            if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u > r_v) begin
                r_u <= r_u - r_v;
            end else begin
                r_v <= r_v - r_u;
            end
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_x * r_b;
        end
    end

    assign sum_w = r_a + r_b;
    assign dif_w = r_a - r_b;

    always_comb begin
        res_val = '0;
        res_st  = ST_OK;
        case (r_op)
            OP_ADD: res_val = 64'(sum_w);
            OP_SUB: res_val = 64'(dif_w);
            OP_MUL: res_val = 64'(r_prod);
            OP_DIV: begin
                if (r_b == '0) res_st = ST_DIV0;
                else if (r_a[W-1] ^ r_b[W-1]) res_val = -(64'(r_dvd));
                else res_val = 64'(r_dvd);
            end
            OP_MOD: begin
                if (r_b == '0) res_st = ST_DIV0;
                else if (r_a[W-1]) res_val = -(64'(r_rem));
                else res_val = 64'(r_rem);
            end
            OP_GCD: begin
                if (o_sts.notpos) res_st = ST_NOTPOS;
                else res_val = 64'(gcd_g);
            end
            OP_LCM: begin
                if (o_sts.notpos) res_st = ST_NOTPOS;
                else res_val = 64'(r_prod);
            end
            default: res_st = ST_BADOP;
        endcase
        if (res_st != ST_OK) res_val = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
        if (i_cmd.finish) begin
            r_res.value  <= res_val;
            r_res.status <= res_st;
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.zero_b   = (r_b == '0);
    assign o_sts.notpos   = (r_a <= 0) || (r_b <= 0);
    assign o_sts.div_last = (r_cnt == CW'(W - 1));
    assign o_sts.gcd_eq   = (r_u == r_v);
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: rtl/integer_alu_with_gcd_lcm_top.sv
// Add, sub and bad op finish straight from decode; mul uses the shared multiplier,
// div/mod the shared bit-serial divider, gcd a binary gcd (one step per cycle),
// and lcm runs gcd, then the shared divider, then the shared multiplier.
// One request at a time: busy stays high until the result beat issues.
// The result beat lasts one cycle; the receiver cannot stall it.
// Synchronous active-low reset returns the controller to idle and drops o_valid.
module integer_alu_with_gcd_lcm_top #(
    parameter int DATA_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ialu_pkg::t_req i_req,
    output logic           o_valid,
    output ialu_pkg::t_res o_res
);
    import ialu_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // controller sequences the steps; datapath holds operands and units
    ialu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ialu_dp #(.W(DATA_WIDTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    // a result beat only closes a request in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result beat without request");

    // accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accept did not raise busy");

    // error results carry zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status != ST_OK) |-> (o_res.value == 64'sd0))
        else $error("nonzero value with error status");

endmodule
